/* sv/assert_macros.svh */
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the base64 line-wrapping encoder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Condition that must never be true at a clock edge.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) `ASSERT_PROP(lbl, clk, rst_n, !(expr))
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

/* sv/b64lw_pkg.sv */
// ---------------------------------------------------------------------------
// b64lw_pkg
// Types, constants and the character table shared by the encoder modules.
// ---------------------------------------------------------------------------
package b64lw_pkg;

  // Default depth of the job queue between front and back.
  localparam int unsigned QueueDepthDefault = 4;

  // Configuration register indexes.
  localparam logic [1:0] CfgLineGroups = 2'd0;
  localparam logic [1:0] CfgDelimWord  = 2'd1;
  localparam logic [1:0] CfgDelimLen   = 2'd2;

  // Configuration reset values.
  localparam logic [7:0]  LineGroupsReset = 8'd20;
  localparam logic [15:0] DelimWordReset  = 16'h0D0A;
  localparam logic [1:0]  DelimLenReset   = 2'd2;

  // Pad character.
  localparam logic [7:0] PadChar = 8'h3D;

  // Number of character slots one job can produce.
  localparam int unsigned NumSlots = 14;

  // One job: everything the back part needs to emit the characters of one byte.
  typedef struct packed {
    logic [23:0] word;        // group or tail bytes, first byte in the top
    logic        wrap_pre;    // delimiter before the full group
    logic        group;       // emit a full four-character group
    logic        wrap_end;    // delimiter from the end-of-message line check
    logic [1:0]  tail_bytes;  // leftover bytes in the tail group (0..2)
    logic        eom;         // message end: final delimiter follows
  } job_t;

  // Queue status seen by the front and back parts.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Maps a six-bit value onto the base64 alphabet.
  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      r = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      r = 8'h2B;
    end else begin
      r = 8'h2F;
    end
    return r;
  endfunction

endpackage

/* sv/b64lw_front.sv */
// ---------------------------------------------------------------------------
// b64lw_front
// Accepts message bytes, keeps the partial group and the line group count,
// and turns every byte that causes output into a job for the back part.
// ---------------------------------------------------------------------------
module b64lw_front import b64lw_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  input  logic [7:0] line_groups_i,
  input  q_status_t  q_status_i,
  output logic       push_o,
  output job_t       job_o
);

  logic [15:0] pend_q, pend_d;
  logic [1:0]  phase_q, phase_d;
  logic [7:0]  gl_q, gl_d;

  logic       accept;
  logic       is_group;
  logic       wrap_pre;
  logic [7:0] gl_grp;
  logic [7:0] gl_mid;

  // A byte is taken whenever the queue has room.
  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !q_status_i.full;

  // Classify the byte and build its job.
  always_comb begin
    is_group = (phase_q >= 2'd2);
    wrap_pre = is_group && (gl_q >= line_groups_i);
    if (wrap_pre) begin
      gl_grp = 8'd1;
    end else if (gl_q == 8'hFF) begin
      gl_grp = gl_q;
    end else begin
      gl_grp = gl_q + 8'd1;
    end
    gl_mid = is_group ? gl_grp : gl_q;

    job_o.wrap_pre = wrap_pre;
    job_o.group    = is_group;
    job_o.eom      = end_of_message_i;
    job_o.wrap_end = end_of_message_i && (gl_mid >= line_groups_i);
    if (is_group) begin
      job_o.word       = {pend_q, data_byte_i};
      job_o.tail_bytes = 2'd0;
    end else if (phase_q == 2'd1) begin
      job_o.word       = {pend_q[15:8], data_byte_i, 8'h00};
      job_o.tail_bytes = 2'd2;
    end else begin
      job_o.word       = {data_byte_i, 16'h0000};
      job_o.tail_bytes = 2'd1;
    end
  end

  assign push_o = accept && (is_group || end_of_message_i);

  // Next group state.
  always_comb begin
    pend_d  = pend_q;
    phase_d = phase_q;
    gl_d    = gl_q;
    if (accept) begin
      if (end_of_message_i) begin
        pend_d  = 16'h0000;
        phase_d = 2'd0;
        gl_d    = 8'd0;
      end else if (is_group) begin
        pend_d  = 16'h0000;
        phase_d = 2'd0;
        gl_d    = gl_grp;
      end else if (phase_q == 2'd1) begin
        pend_d  = {pend_q[15:8], data_byte_i};
        phase_d = 2'd2;
      end else begin
        pend_d  = {data_byte_i, 8'h00};
        phase_d = 2'd1;
      end
    end
  end

  // Group state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q  <= '0;
      phase_q <= '0;
      gl_q    <= '0;
    end else begin
      pend_q  <= pend_d;
      phase_q <= phase_d;
      gl_q    <= gl_d;
    end
  end

endmodule

/* sv/b64lw_fifo.sv */
// ---------------------------------------------------------------------------
// b64lw_fifo
// Short job queue that decouples the byte front from the character back.
// ---------------------------------------------------------------------------
module b64lw_fifo import b64lw_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  job_t      job_i,
  input  logic      pop_i,
  output job_t      job_o,
  output q_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            entries_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;

  assign status_o.full  = (cnt_q == FullCnt);
  assign status_o.empty = (cnt_q == '0);
  assign job_o          = entries_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= job_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (!push_i && pop_i) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

/* sv/b64lw_back.sv */
// ---------------------------------------------------------------------------
// b64lw_back
// Expands each job into its character slots and sends one character per
// cycle through a registered output while the output is not stalled.
// ---------------------------------------------------------------------------
module b64lw_back import b64lw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  q_status_t   q_status_i,
  input  job_t        job_i,
  output logic        pop_o,
  input  logic [15:0] delim_word_i,
  input  logic [1:0]  delim_len_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        run_last_o
);

  // Character slots in emission order.
  localparam logic [3:0] SlotPreD0  = 4'd0;
  localparam logic [3:0] SlotPreD1  = 4'd1;
  localparam logic [3:0] SlotGrp0   = 4'd2;
  localparam logic [3:0] SlotGrp1   = 4'd3;
  localparam logic [3:0] SlotGrp2   = 4'd4;
  localparam logic [3:0] SlotGrp3   = 4'd5;
  localparam logic [3:0] SlotEndD0  = 4'd6;
  localparam logic [3:0] SlotEndD1  = 4'd7;
  localparam logic [3:0] SlotTail0  = 4'd8;
  localparam logic [3:0] SlotTail1  = 4'd9;
  localparam logic [3:0] SlotTail2  = 4'd10;
  localparam logic [3:0] SlotTail3  = 4'd11;
  localparam logic [3:0] SlotFinD0  = 4'd12;
  localparam logic [3:0] SlotFinD1  = 4'd13;

  job_t                job_q;
  logic [NumSlots-1:0] mask_q;
  logic                out_valid_q;
  logic [7:0]          out_char_q;
  logic                out_last_q;

  logic                dn1, dn2;
  logic [NumSlots-1:0] new_mask;
  logic [NumSlots-1:0] rem;
  logic [3:0]          slot;
  logic                found;
  logic                active;
  logic                advance;
  logic                load;
  logic                has_tail;
  logic [7:0]          ch;

  // Delimiter length three behaves as two.
  assign dn1 = (delim_len_i != 2'd0);
  assign dn2 = (delim_len_i >= 2'd2);

  // Slot mask of the job at the queue head.
  always_comb begin
    has_tail            = (job_i.tail_bytes != 2'd0);
    new_mask            = '0;
    new_mask[SlotPreD0] = job_i.wrap_pre && dn1;
    new_mask[SlotPreD1] = job_i.wrap_pre && dn2;
    new_mask[SlotGrp0]  = job_i.group;
    new_mask[SlotGrp1]  = job_i.group;
    new_mask[SlotGrp2]  = job_i.group;
    new_mask[SlotGrp3]  = job_i.group;
    new_mask[SlotEndD0] = job_i.wrap_end && dn1;
    new_mask[SlotEndD1] = job_i.wrap_end && dn2;
    new_mask[SlotTail0] = has_tail;
    new_mask[SlotTail1] = has_tail;
    new_mask[SlotTail2] = has_tail;
    new_mask[SlotTail3] = has_tail;
    new_mask[SlotFinD0] = job_i.eom && dn1;
    new_mask[SlotFinD1] = job_i.eom && dn2;
  end

  // Lowest pending slot of the current job.
  always_comb begin
    slot  = '0;
    found = 1'b0;
    for (int i = 0; i < NumSlots; i++) begin
      if (mask_q[i] && !found) begin
        slot  = 4'(i);
        found = 1'b1;
      end
    end
    rem = mask_q & (mask_q - NumSlots'(1));
  end

  // Character for the selected slot.
  always_comb begin
    case (slot)
      SlotPreD0, SlotEndD0, SlotFinD0: ch = delim_word_i[15:8];
      SlotPreD1, SlotEndD1, SlotFinD1: ch = delim_word_i[7:0];
      SlotGrp0, SlotTail0:             ch = sextet_char(job_q.word[23:18]);
      SlotGrp1, SlotTail1:             ch = sextet_char(job_q.word[17:12]);
      SlotGrp2:                        ch = sextet_char(job_q.word[11:6]);
      SlotGrp3:                        ch = sextet_char(job_q.word[5:0]);
      SlotTail2: begin
        ch = (job_q.tail_bytes == 2'd2) ? sextet_char(job_q.word[11:6]) : PadChar;
      end
      SlotTail3:                       ch = PadChar;
      default:                         ch = PadChar;
    endcase
  end

  // Emit when the output register is free or being drained; fetch the next
  // job in the cycle the last slot of the current one goes out.
  assign active  = (mask_q != '0);
  assign advance = active && (!out_valid_q || !out_stall_i);
  assign load    = !q_status_i.empty && (!active || (advance && (rem == '0)));
  assign pop_o   = load;

  // Job payload.
  always_ff @(posedge clk_i) begin
    if (load) begin
      job_q <= job_i;
    end
    if (advance) begin
      out_char_q <= ch;
      out_last_q <= (rem == '0);
    end
  end

  // Slot mask and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        mask_q <= new_mask;
      end else if (advance) begin
        mask_q <= rem;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign run_last_o  = out_last_q;

endmodule

/* sv/base64_line_wrapping_encoder.sv */
// Path: the job of a byte passes the job queue, the job register and slot mask of
// the back, then the output register; the characters of one byte follow one per cycle.
// Throughput: one character per cycle while jobs are queued and the receiver does
// not stall, set by the single output register.
// Reset: asynchronous, active low; clears the group state, the job queue and
// the output, and loads the configuration defaults. No clearing pass.
// ---------------------------------------------------------------------------
// base64_line_wrapping_encoder
// Base64 encoder with line wrapping: a byte front classifies input into jobs,
// a short queue carries them to a back part that emits the characters.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module base64_line_wrapping_encoder import b64lw_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration writes.
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  // Input bytes.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_message_i,
  // Output characters.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_char_o,
  output logic        run_last_o
);

  logic [7:0]  line_groups_q;
  logic [15:0] delim_word_q;
  logic [1:0]  delim_len_q;

  logic      push;
  logic      pop;
  job_t      push_job;
  job_t      head_job;
  q_status_t q_status;

  // Configuration registers; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_groups_q <= LineGroupsReset;
      delim_word_q  <= DelimWordReset;
      delim_len_q   <= DelimLenReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgLineGroups: line_groups_q <= cfg_data_i[7:0];
        CfgDelimWord:  delim_word_q  <= cfg_data_i;
        CfgDelimLen:   delim_len_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  // Byte front.
  b64lw_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .line_groups_i    (line_groups_q),
    .q_status_i       (q_status),
    .push_o           (push),
    .job_o            (push_job)
  );

  // Job queue.
  b64lw_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (push_job),
    .pop_i    (pop),
    .job_o    (head_job),
    .status_o (q_status)
  );

  // Character back.
  b64lw_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_status_i   (q_status),
    .job_i        (head_job),
    .pop_o        (pop),
    .delim_word_i (delim_word_q),
    .delim_len_i  (delim_len_q),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_char_o   (out_char_o),
    .run_last_o   (run_last_o)
  );

  // The front never writes a full queue and the back never reads an empty one.
  `ASSERT_NEVER(a_push_when_full, clk_i, rst_ni, push && q_status.full)
  `ASSERT_NEVER(a_pop_when_empty, clk_i, rst_ni, pop && q_status.empty)
  // Characters of one byte leave without gaps once the first is taken.
  `ASSERT_PROP(a_run_no_gap, clk_i, rst_ni,
               (out_valid_o && !out_stall_i && !run_last_o) |=> out_valid_o)

endmodule

/* tb/base64_line_wrapping_encoder_tb.sv */
// ---------------------------------------------------------------------------
// base64_line_wrapping_encoder_tb
// Self-checking bench for the line-wrapping base64 encoder. A directed table
// covers known encodings, extremes and register corner cases. Random messages
// then run under several line and delimiter settings and stall patterns.
// Every output character is checked against a bench-side encoder.
// ---------------------------------------------------------------------------
module base64_line_wrapping_encoder_tb import b64lw_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ClkPeriod     = 8;
  localparam int LatencyGap    = 8;
  localparam int HoldCycles    = 250;
  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 36;
  localparam int DrainLimit    = 50000;
  localparam int TimeoutNs     = 4000000;

  // Index past the last register; writes to it must be ignored.
  localparam logic [1:0] CfgNoReg = 2'd3;

  localparam string Base64Set =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef enum logic {RowByte, RowReg} row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    logic [1:0]  idx;
    logic [15:0] value;
    logic        eom;
  } row_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } b64_char_t;

  // Ports of the block.
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        cfg_valid_i      = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i      = '0;
  logic [15:0] cfg_data_i       = '0;
  logic        in_valid_i       = 1'b0;
  logic        in_stall_o;
  logic [7:0]  data_byte_i      = '0;
  logic        end_of_message_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i      = 1'b0;
  logic [7:0]  out_char_o;
  logic        run_last_o;

  // Encoder copy: configuration and group state.
  logic [7:0]  line_groups_q = LineGroupsReset;
  logic [15:0] delim_word_q  = DelimWordReset;
  logic [1:0]  delim_len_q   = DelimLenReset;
  logic [15:0] held_q        = '0;
  logic [1:0]  phase_q       = '0;
  logic [7:0]  grp_cnt_q     = '0;

  // Characters still to come from the block, oldest first.
  b64_char_t   expected_chars[$];
  logic [7:0]  item_chars[$];
  string       typed_chars = "";

  row_t        rows[$];
  string       row_text[$];

  int          idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_tgl = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;

  int unsigned mismatches = 0;
  int unsigned n_bytes = 0;
  int unsigned n_msgs = 0;
  int unsigned n_chars = 0;
  int unsigned n_writes = 0;

  base64_line_wrapping_encoder dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_message_i(end_of_message_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .run_last_o      (run_last_o)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #(TimeoutNs);
    $display("Timeout with %0d characters outstanding.", expected_chars.size());
    $display("*** FAILED ***");
    $finish;
  end

  task automatic report_error(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void put_delimiter();
    int unsigned n;
    n = (delim_len_q > 2'd2) ? 2 : delim_len_q;
    if (n >= 1) item_chars.push_back(delim_word_q[15:8]);
    if (n >= 2) item_chars.push_back(delim_word_q[7:0]);
  endfunction

  function automatic void put_sextet(input logic [5:0] v);
    item_chars.push_back(Base64Set[v]);
  endfunction

  function automatic void apply_reg(input logic [1:0] idx, input logic [15:0] val);
    case (idx)
      CfgLineGroups: line_groups_q = val[7:0];
      CfgDelimWord:  delim_word_q  = val;
      CfgDelimLen:   delim_len_q   = val[1:0];
      default: ;
    endcase
  endfunction

  // Encodes one accepted byte and queues the characters it causes.
  function automatic void encode_byte(input logic [7:0] b, input logic eom);
    logic [23:0] word;
    b64_char_t   c;
    item_chars.delete();
    if (phase_q == 2'd2) begin
      word = {held_q, b};
      if (grp_cnt_q >= line_groups_q) begin
        put_delimiter();
        grp_cnt_q = '0;
      end
      put_sextet(word[23:18]);
      put_sextet(word[17:12]);
      put_sextet(word[11:6]);
      put_sextet(word[5:0]);
      if (grp_cnt_q != 8'hFF) grp_cnt_q = grp_cnt_q + 8'd1;
      held_q  = '0;
      phase_q = 2'd0;
    end else if (phase_q == 2'd1) begin
      held_q[7:0] = b;
      phase_q     = 2'd2;
    end else begin
      held_q  = {b, 8'h00};
      phase_q = 2'd1;
    end

    // Message end: line check, padded tail, then the closing delimiter.
    if (eom) begin
      word = {held_q, 8'h00};
      if (grp_cnt_q >= line_groups_q) put_delimiter();
      if (phase_q == 2'd2) begin
        put_sextet(word[23:18]);
        put_sextet(word[17:12]);
        put_sextet(word[11:6]);
        item_chars.push_back(PadChar);
      end else if (phase_q == 2'd1) begin
        put_sextet(word[23:18]);
        put_sextet(word[17:12]);
        item_chars.push_back(PadChar);
        item_chars.push_back(PadChar);
      end
      put_delimiter();
      held_q    = '0;
      phase_q   = 2'd0;
      grp_cnt_q = '0;
    end

    // A row of the directed table may carry its characters typed in.
    if (typed_chars.len() != 0) begin
      item_chars.delete();
      for (int i = 0; i < typed_chars.len(); i++) item_chars.push_back(typed_chars[i]);
    end
    for (int i = 0; i < item_chars.size(); i++) begin
      c.ch   = item_chars[i];
      c.last = (i == item_chars.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  task automatic check_char(input logic [7:0] ch, input logic last);
    b64_char_t e;
    n_chars++;
    if (expected_chars.size() == 0) begin
      report_error($sformatf("character 0x%02h with nothing expected", ch));
    end else begin
      e = expected_chars.pop_front();
      if (ch !== e.ch) begin
        report_error($sformatf("out_char 0x%02h, expected 0x%02h", ch, e.ch));
      end
      if (last !== e.last) begin
        report_error($sformatf("run_last %b, expected %b (char 0x%02h)", last, e.last, e.ch));
      end
    end
  endtask

  // Every transfer is observed at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_reg(cfg_index_i, cfg_data_i);
        n_writes++;
      end
      if (in_valid_i && !in_stall_o) begin
        encode_byte(data_byte_i, end_of_message_i);
        n_bytes++;
        if (end_of_message_i) n_msgs++;
      end
      if (out_valid_o && !out_stall_i) check_char(out_char_o, run_last_o);
    end
  end

  // Receiver: random stalls, or a long hold-off when the sender asks for one.
  always @(negedge clk_i) begin
    if (hold_tgl != hold_seen) begin
      hold_seen   <= hold_tgl;
      hold_left   <= HoldCycles - 1;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic eom, input string typed);
    @(negedge clk_i);
    in_valid_i       <= 1'b1;
    data_byte_i      <= b;
    end_of_message_i <= eom;
    typed_chars       = typed;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
  endtask

  task automatic sender_gap();
    while ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Stops sending and lets every expected character drain out.
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (LatencyGap) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void add_byte(input logic [7:0] b, input logic eom, input string typed);
    row_t r;
    r.kind  = RowByte;
    r.idx   = '0;
    r.value = {8'h00, b};
    r.eom   = eom;
    rows.push_back(r);
    row_text.push_back(typed);
  endfunction

  function automatic void add_reg(input logic [1:0] idx, input logic [15:0] val);
    row_t r;
    r.kind  = RowReg;
    r.idx   = idx;
    r.value = val;
    r.eom   = 1'b0;
    rows.push_back(r);
    row_text.push_back("");
  endfunction

  initial begin : stimulus
    int          sent;
    int          msg_len;
    int          wait_n;
    logic [7:0]  lg;
    logic [15:0] dw;
    logic [1:0]  dl;

    // Known encodings at reset settings, then the byte extremes.
    add_byte(8'h4D, 1'b1, "TQ==\015\012");
    add_byte(8'h4D, 1'b0, "");
    add_byte(8'h61, 1'b1, "TWE=\015\012");
    add_byte(8'h4D, 1'b0, "");
    add_byte(8'h61, 1'b0, "");
    add_byte(8'h6E, 1'b1, "TWFu\015\012");
    add_byte(8'h00, 1'b0, "");
    add_byte(8'h00, 1'b0, "");
    add_byte(8'h00, 1'b0, "AAAA");
    add_byte(8'hFF, 1'b0, "");
    add_byte(8'hFF, 1'b0, "");
    add_byte(8'hFF, 1'b1, "////\015\012");
    // Zero groups per line wraps before every group; length three acts as two.
    add_reg(CfgLineGroups, 16'd0);
    add_reg(CfgDelimLen, 16'd3);
    add_byte(8'h12, 1'b0, "");
    add_byte(8'h34, 1'b0, "");
    add_byte(8'h56, 1'b1, "");
    // One group per line, one-byte delimiter, end check with a full line.
    add_reg(CfgDelimWord, 16'hFFFF);
    add_reg(CfgDelimLen, 16'd1);
    add_reg(CfgLineGroups, 16'd1);
    add_byte(8'hFF, 1'b0, "");
    add_byte(8'h00, 1'b0, "");
    add_byte(8'hFF, 1'b0, "");
    add_byte(8'h00, 1'b0, "");
    add_byte(8'hFF, 1'b1, "");
    // No delimiter at all; a write past the last register changes nothing.
    add_reg(CfgDelimLen, 16'd0);
    add_reg(CfgDelimWord, 16'h0000);
    add_reg(CfgNoReg, 16'hFFFF);
    add_reg(CfgLineGroups, 16'd255);
    add_byte(8'hA5, 1'b1, "");
    // Back to the reset settings.
    add_reg(CfgLineGroups, {8'h00, LineGroupsReset});
    add_reg(CfgDelimWord, DelimWordReset);
    add_reg(CfgDelimLen, {14'h0, DelimLenReset});
    add_byte(8'h5A, 1'b0, "");
    add_byte(8'hC3, 1'b1, "");

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table.
    for (int r = 0; r < rows.size(); r++) begin
      if (rows[r].kind == RowReg) begin
        wait_idle();
        write_reg(rows[r].idx, rows[r].value);
      end else begin
        send_byte(rows[r].value[7:0], rows[r].eom, row_text[r]);
      end
    end

    // Random messages, one phase per register setting and stall pattern.
    for (int p = 0; p < NumPhases; p++) begin
      wait_idle();
      dw = 16'($urandom_range(0, 65535));
      case (p)
        0: begin lg = 8'd20; dw = 16'h0D0A; dl = 2'd2; end
        1: begin lg = 8'd1; dl = 2'd1; end
        2: begin lg = 8'd2; dl = 2'd3; end
        3: begin lg = 8'd0; dl = 2'd2; end
        4: begin lg = 8'd255; dl = 2'd0; end
        5: begin lg = 8'($urandom_range(1, 4)); dl = 2'($urandom_range(0, 3)); end
        6: begin lg = 8'd3; dw = 16'hFFFF; dl = 2'd2; end
        default: begin lg = 8'($urandom_range(1, 8)); dl = 2'($urandom_range(0, 3)); end
      endcase
      write_reg(CfgLineGroups, {8'h00, lg});
      write_reg(CfgDelimWord, dw);
      write_reg(CfgDelimLen, {14'h0, dl});

      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 74; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 74; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase

      // Long receiver hold-off while bytes keep coming, so the input backs up.
      if (p == 0) hold_tgl = ~hold_tgl;

      sent = 0;
      while (sent < ItemsPerPhase) begin
        if ($urandom_range(0, 99) < 80) msg_len = $urandom_range(1, 9);
        else msg_len = $urandom_range(10, 40);
        if (msg_len > ItemsPerPhase - sent) msg_len = ItemsPerPhase - sent;
        for (int k = 0; k < msg_len; k++) begin
          sender_gap();
          send_byte(8'($urandom_range(0, 255)), (k == msg_len - 1), "");
        end
        sent += msg_len;
        // Sender pause until the block has delivered everything.
        if (p == 4 && sent >= ItemsPerPhase / 2 && sent - msg_len < ItemsPerPhase / 2) begin
          wait_idle();
        end
      end
    end

    // Drain with a bound, then allow for stray characters.
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    for (wait_n = 0; wait_n < DrainLimit && expected_chars.size() != 0; wait_n++) begin
      @(posedge clk_i);
    end
    repeat (LatencyGap * 4) @(posedge clk_i);
    if (expected_chars.size() != 0) begin
      report_error($sformatf("%0d characters never arrived", expected_chars.size()));
    end

    $display("Run covered %0d bytes in %0d messages, %0d characters, %0d register writes.",
             n_bytes, n_msgs, n_chars, n_writes);
    $display("Line groups 0..255, delimiter lengths 0..3, four stall patterns, %0d mismatches.",
             mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
